/* src/ptca_pkg.sv */
`timescale 1ns / 1ps

package ptca_pkg;

  localparam int unsigned EchoWidth   = 16;
  localparam int unsigned CmdWidth    = 8;
  localparam int unsigned DayWidth    = 5;
  localparam int unsigned HourWidth   = 5;
  localparam int unsigned MinuteWidth = 6;
  localparam int unsigned SecondWidth = 6;
  localparam int unsigned RecordWidth = 16;

  localparam int unsigned CountWidthDefault = 16;
  localparam logic [EchoWidth-1:0] MarginReset = 16'd580;

  localparam logic [CmdWidth-1:0] CmdStats     = 8'h30;
  localparam logic [CmdWidth-1:0] CmdSecurity  = 8'h31;
  localparam logic [CmdWidth-1:0] CmdCalibrate = 8'h32;
  localparam logic [CmdWidth-1:0] CmdClear     = 8'h34;
  localparam logic [CmdWidth-1:0] CmdAlarmOff  = 8'h35;
  localparam logic [CmdWidth-1:0] CmdDaily     = 8'h36;
  localparam logic [CmdWidth-1:0] CmdHourly    = 8'h37;
  localparam logic [CmdWidth-1:0] CmdMinute    = 8'h38;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_ALARM  = 2'd1,
    KIND_ACK    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    IVL_DAY    = 2'd0,
    IVL_HOUR   = 2'd1,
    IVL_MINUTE = 2'd2
  } interval_e;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [RecordWidth-1:0] record_count;
    logic [DayWidth-1:0]    stamp_day;
    logic [HourWidth-1:0]   stamp_hour;
    logic [MinuteWidth-1:0] stamp_minute;
    logic [SecondWidth-1:0] stamp_second;
    logic [CmdWidth-1:0]    ack_code;
    logic                   buzzer_on;
    logic                   security_mode;
    logic [1:0]             interval_mode;
  } result_t;

endpackage

/* src/ptca_if.sv */
`timescale 1ns / 1ps

interface ptca_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [ptca_pkg::EchoWidth-1:0]        echo_us;
  logic [ptca_pkg::CmdWidth-1:0]         cmd_byte;
  logic [ptca_pkg::DayWidth-1:0]         now_day;
  logic [ptca_pkg::HourWidth-1:0]        now_hour;
  logic [ptca_pkg::MinuteWidth-1:0]      now_minute;
  logic [ptca_pkg::SecondWidth-1:0]      now_second;

  modport source (
    output valid, action, echo_us, cmd_byte, now_day, now_hour, now_minute, now_second,
    input  ready
  );
  modport sink (
    input  valid, action, echo_us, cmd_byte, now_day, now_hour, now_minute, now_second,
    output ready
  );
endinterface

interface ptca_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            result_kind;
  logic [ptca_pkg::RecordWidth-1:0]      record_count;
  logic [ptca_pkg::DayWidth-1:0]         stamp_day;
  logic [ptca_pkg::HourWidth-1:0]        stamp_hour;
  logic [ptca_pkg::MinuteWidth-1:0]      stamp_minute;
  logic [ptca_pkg::SecondWidth-1:0]      stamp_second;
  logic [ptca_pkg::CmdWidth-1:0]         ack_code;
  logic                                  buzzer_on;
  logic                                  security_mode;
  logic [1:0]                            interval_mode;

  modport source (
    output valid, result_kind, record_count, stamp_day, stamp_hour, stamp_minute,
           stamp_second, ack_code, buzzer_on, security_mode, interval_mode,
    input  ready
  );
  modport sink (
    input  valid, result_kind, record_count, stamp_day, stamp_hour, stamp_minute,
           stamp_second, ack_code, buzzer_on, security_mode, interval_mode,
    output ready
  );
endinterface

/* src/presence_traffic_counter_alarm_core.sv */
`timescale 1ns / 1ps

// Presence traffic counter with alarm.
// item_i carries one item: a distance reading (echo width plus time of day)
// or a command byte. result_o carries at most one result per item: a traffic
// record, an alarm event or a command acknowledgement.
// cfg_we_i / cfg_wdata_i write the calibration margin in echo microseconds.
// Each item is handled in the cycle it is accepted; its result, if any, sits
// in the output register from the next cycle on.
// One item is accepted per cycle. item_i.ready is high while the output
// register is empty or its result is taken in the same cycle; while the
// receiver stalls a pending result, the result holds and input stalls.
// Items that cause no result update state only.
// Reset clears all state but the output data: statistics mode, per-minute
// intervals, threshold and count at zero, alarm off, margin back to 580.
module presence_traffic_counter_alarm_core #(
  parameter int unsigned COUNT_WIDTH = ptca_pkg::CountWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptca_in_if.sink                        item_i,
  ptca_out_if.source                     result_o,
  input  logic                           cfg_we_i,
  input  logic [ptca_pkg::EchoWidth-1:0] cfg_wdata_i
);

  logic [ptca_pkg::EchoWidth-1:0]   margin_q;
  logic                             mode_q, mode_d;
  logic [1:0]                       interval_q, interval_d;
  logic [ptca_pkg::EchoWidth-1:0]   threshold_q, threshold_d;
  logic                             inside_q, inside_d;
  logic [COUNT_WIDTH-1:0]           count_q, count_d;
  logic [ptca_pkg::DayWidth-1:0]    ref_day_q, ref_day_d;
  logic [ptca_pkg::HourWidth-1:0]   ref_hour_q, ref_hour_d;
  logic [ptca_pkg::MinuteWidth-1:0] ref_minute_q, ref_minute_d;
  logic                             alarm_q, alarm_d;

  logic                             out_valid_q;
  ptca_pkg::result_t                out_q;
  ptca_pkg::result_t                res;
  logic                             emit;
  logic                             accept;
  logic                             near;
  logic                             changed;
  logic [31:0]                      count_ext;
  logic [COUNT_WIDTH-1:0]           count_base;

  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;
  assign near         = item_i.echo_us < threshold_q;
  assign count_ext    = 32'(count_q);

  always_comb begin
    mode_d       = mode_q;
    interval_d   = interval_q;
    threshold_d  = threshold_q;
    inside_d     = inside_q;
    count_d      = count_q;
    ref_day_d    = ref_day_q;
    ref_hour_d   = ref_hour_q;
    ref_minute_d = ref_minute_q;
    alarm_d      = alarm_q;
    emit         = 1'b0;
    changed      = 1'b0;
    count_base   = count_q;
    res          = '0;

    if (item_i.action) begin
      emit = 1'b1;
      res.result_kind = ptca_pkg::KIND_ACK;
      res.ack_code    = item_i.cmd_byte;
      unique case (item_i.cmd_byte)
        ptca_pkg::CmdStats:     mode_d = 1'b0;
        ptca_pkg::CmdSecurity:  mode_d = 1'b1;
        ptca_pkg::CmdCalibrate: begin
          threshold_d = (item_i.echo_us > margin_q) ? item_i.echo_us - margin_q : '0;
        end
        ptca_pkg::CmdClear:     count_d = '0;
        ptca_pkg::CmdAlarmOff:  alarm_d = 1'b0;
        ptca_pkg::CmdDaily:     interval_d = ptca_pkg::IVL_DAY;
        ptca_pkg::CmdHourly:    interval_d = ptca_pkg::IVL_HOUR;
        ptca_pkg::CmdMinute:    interval_d = ptca_pkg::IVL_MINUTE;
        default:                emit = 1'b0;
      endcase
    end else if (!alarm_q) begin
      res.stamp_day    = item_i.now_day;
      res.stamp_hour   = item_i.now_hour;
      res.stamp_minute = item_i.now_minute;
      res.stamp_second = item_i.now_second;
      if (mode_q) begin
        if (near) begin
          alarm_d         = 1'b1;
          emit            = 1'b1;
          res.result_kind = ptca_pkg::KIND_ALARM;
        end
      end else if (near) begin
        inside_d = 1'b1;
      end else if (inside_q) begin
        inside_d = 1'b0;
        unique case (interval_q)
          ptca_pkg::IVL_DAY:    changed = ref_day_q != item_i.now_day;
          ptca_pkg::IVL_HOUR:   changed = ref_hour_q != item_i.now_hour;
          ptca_pkg::IVL_MINUTE: changed = ref_minute_q != item_i.now_minute;
          default:              changed = 1'b0;
        endcase
        if (interval_q != 2'd3) begin
          if (changed) begin
            emit             = 1'b1;
            res.result_kind  = ptca_pkg::KIND_RECORD;
            res.record_count = (count_ext > 32'hFFFF) ? 16'hFFFF : count_ext[15:0];
            count_base       = '0;
            ref_day_d        = item_i.now_day;
            ref_hour_d       = item_i.now_hour;
            ref_minute_d     = item_i.now_minute;
          end
          count_d = (&count_base) ? count_base : count_base + 1'b1;
        end
      end
    end

    res.buzzer_on     = alarm_d;
    res.security_mode = mode_d;
    res.interval_mode = interval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q     <= ptca_pkg::MarginReset;
      mode_q       <= 1'b0;
      interval_q   <= ptca_pkg::IVL_MINUTE;
      threshold_q  <= '0;
      inside_q     <= 1'b0;
      count_q      <= '0;
      ref_day_q    <= '0;
      ref_hour_q   <= '0;
      ref_minute_q <= '0;
      alarm_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        margin_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q       <= mode_d;
        interval_q   <= interval_d;
        threshold_q  <= threshold_d;
        inside_q     <= inside_d;
        count_q      <= count_d;
        ref_day_q    <= ref_day_d;
        ref_hour_q   <= ref_hour_d;
        ref_minute_q <= ref_minute_d;
        alarm_q      <= alarm_d;
        out_valid_q  <= emit;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.result_kind   = out_q.result_kind;
  assign result_o.record_count  = out_q.record_count;
  assign result_o.stamp_day     = out_q.stamp_day;
  assign result_o.stamp_hour    = out_q.stamp_hour;
  assign result_o.stamp_minute  = out_q.stamp_minute;
  assign result_o.stamp_second  = out_q.stamp_second;
  assign result_o.ack_code      = out_q.ack_code;
  assign result_o.buzzer_on     = out_q.buzzer_on;
  assign result_o.security_mode = out_q.security_mode;
  assign result_o.interval_mode = out_q.interval_mode;

endmodule
